### src/cfl_pkg.sv
// Shared types, character codes and helper functions for the configuration text lexer.
`timescale 1ns / 1ps

package cfl_pkg;

  typedef enum logic [2:0] {
    MODE_START   = 3'd0,
    MODE_NUMERAL = 3'd1,
    MODE_STRING  = 3'd2,
    MODE_ESCAPE  = 3'd3,
    MODE_IDENT   = 3'd4,
    MODE_COMMENT = 3'd5,
    MODE_DONE    = 3'd6
  } lex_mode_t;

  localparam logic [2:0] KIND_END     = 3'd0;
  localparam logic [2:0] KIND_LBRACE  = 3'd1;
  localparam logic [2:0] KIND_RBRACE  = 3'd2;
  localparam logic [2:0] KIND_EQUAL   = 3'd3;
  localparam logic [2:0] KIND_NUMERAL = 3'd4;
  localparam logic [2:0] KIND_STRING  = 3'd5;
  localparam logic [2:0] KIND_IDENT   = 3'd6;
  localparam logic [2:0] KIND_ERROR   = 3'd7;

  localparam logic [1:0] ERR_NONE   = 2'd0;
  localparam logic [1:0] ERR_SYMBOL = 2'd1;
  localparam logic [1:0] ERR_ESCAPE = 2'd2;

  localparam logic [7:0] CH_NUL       = 8'h00;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_LF        = 8'h0A;
  localparam logic [7:0] CH_CR        = 8'h0D;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_HASH      = 8'h23;
  localparam logic [7:0] CH_DOT       = 8'h2E;
  localparam logic [7:0] CH_EQUAL     = 8'h3D;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_UNDERLINE = 8'h5F;
  localparam logic [7:0] CH_LOWER_N   = 8'h6E;
  localparam logic [7:0] CH_LOWER_R   = 8'h72;
  localparam logic [7:0] CH_LOWER_T   = 8'h74;
  localparam logic [7:0] CH_LBRACE    = 8'h7B;
  localparam logic [7:0] CH_RBRACE    = 8'h7D;
  localparam logic [7:0] CH_TILDE     = 8'h7E;

  // Fixed-width part of one result word; numeral value and position travel beside it.
  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] text;
    logic       has_byte;
    logic       tok_end;
    logic [1:0] err;
  } tok_info_t;

  localparam int INFO_BITS = $bits(tok_info_t);

  function automatic tok_info_t mk_info(logic [2:0] kind, logic [7:0] text, logic has_byte,
                                        logic tok_end, logic [1:0] err);
    tok_info_t t;
    t.kind     = kind;
    t.text     = text;
    t.has_byte = has_byte;
    t.tok_end  = tok_end;
    t.err      = err;
    return t;
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
  endfunction

  function automatic logic is_ident_tail(logic [7:0] c);
    return is_alpha(c) || is_digit(c) || c == CH_UNDERLINE || c == CH_DOT;
  endfunction

endpackage

### src/cfl_queue.sv
// Result queue that takes up to two words per cycle and hands out one.
`timescale 1ns / 1ps

module cfl_queue #(
  parameter int WIDTH = 78,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [1:0]       push_count,
  input  logic [WIDTH-1:0] push_data0,
  input  logic [WIDTH-1:0] push_data1,
  output logic             room_for_two,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]    data [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr, wr_ptr_next, rd_ptr, rd_ptr_next, wr_ptr_plus1;
  logic [CNT_BITS-1:0] count, count_next;
  logic                pop;

  function automatic logic [PTR_BITS-1:0] ptr_inc(logic [PTR_BITS-1:0] p);
    return (p == PTR_BITS'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign pop          = out_valid && out_ready;
  assign out_valid    = (count != '0);
  assign out_data     = data[rd_ptr];
  assign room_for_two = (count <= CNT_BITS'(DEPTH - 2));
  assign wr_ptr_plus1 = ptr_inc(wr_ptr);

  always_comb begin
    rd_ptr_next = pop ? ptr_inc(rd_ptr) : rd_ptr;
    case (push_count)
      2'd1:    wr_ptr_next = wr_ptr_plus1;
      2'd2:    wr_ptr_next = ptr_inc(wr_ptr_plus1);
      default: wr_ptr_next = wr_ptr;
    endcase
    count_next = count + CNT_BITS'(push_count) - CNT_BITS'(pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      data[wr_ptr] <= push_data0;
    end
    if (push_count == 2'd2) begin
      data[wr_ptr_plus1] <= push_data1;
    end
  end

  // The occupancy never goes past the storage.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_BITS'(DEPTH))
    else $error("result queue overflow");

  // Words are only pushed when the producer has seen room for two.
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push_count != 2'd0 |-> room_for_two)
    else $error("push into a queue without room");

  // A pop with nothing pushed shrinks the occupancy by one.
  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    (pop && push_count == 2'd0) |=> count == $past(count) - 1'b1)
    else $error("pop did not reduce the occupancy");

endmodule

### src/cfl_step.sv
// Lexer state registers and the single-pass logic that turns one character into its results.
`timescale 1ns / 1ps

module cfl_step #(
  parameter int POS_BITS    = 16,
  parameter int NUMBER_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   advance,
  input  logic [7:0]             char_code,
  input  logic                   end_of_input,
  output logic [1:0]             res_count,
  output cfl_pkg::tok_info_t     info0,
  output cfl_pkg::tok_info_t     info1,
  output logic [NUMBER_BITS-1:0] num0,
  output logic [NUMBER_BITS-1:0] num1,
  output logic [POS_BITS-1:0]    row0,
  output logic [POS_BITS-1:0]    col0,
  output logic [POS_BITS-1:0]    row1,
  output logic [POS_BITS-1:0]    col1
);

  import cfl_pkg::*;

  localparam logic [POS_BITS-1:0]    POS_MAX = '1;
  localparam logic [NUMBER_BITS-1:0] NUM_MAX = '1;

  lex_mode_t               mode, mode_next;
  logic [POS_BITS-1:0]     cur_row, cur_row_next, cur_col, cur_col_next;
  logic [POS_BITS-1:0]     token_row, token_row_next, token_col, token_col_next;
  logic [NUMBER_BITS-1:0]  number_acc, number_acc_next;
  logic                    prev_nl, prev_nl_next;

  logic [POS_BITS-1:0]     row, col;
  logic [NUMBER_BITS+3:0]  acc_x10;
  logic [NUMBER_BITS-1:0]  acc_grown, digit_val;

  // Outcome of treating the character as the first one of a token.
  logic                    sc_emit, sc_set_pos, sc_set_acc;
  tok_info_t               sc_info;
  lex_mode_t               sc_mode;
  tok_info_t               close_info;
  logic [2:0]              close_kind;
  logic [7:0]              esc_byte;
  logic                    esc_ok;

  function automatic logic [POS_BITS-1:0] sat_inc(logic [POS_BITS-1:0] v);
    return (v == POS_MAX) ? POS_MAX : v + 1'b1;
  endfunction

  assign row       = prev_nl ? sat_inc(cur_row) : cur_row;
  assign col       = prev_nl ? POS_BITS'(1) : cur_col;
  assign digit_val = NUMBER_BITS'(char_code[3:0]);

  // acc * 10 + digit by shifts; saturate when it leaves the numeral range.
  assign acc_x10   = ({4'b0, number_acc} << 3) + ({4'b0, number_acc} << 1)
                     + (NUMBER_BITS + 4)'(char_code[3:0]);
  assign acc_grown = (acc_x10 > {4'b0, NUM_MAX}) ? NUM_MAX : acc_x10[NUMBER_BITS-1:0];

  always_comb begin
    sc_emit    = 1'b0;
    sc_set_pos = 1'b1;
    sc_set_acc = 1'b0;
    sc_mode    = MODE_START;
    sc_info    = mk_info(KIND_END, 8'h00, 1'b0, 1'b1, ERR_NONE);
    if (char_code == CH_SPACE || char_code == CH_TAB || char_code == CH_LF) begin
      sc_set_pos = 1'b0;
    end else if (char_code == CH_NUL) begin
      sc_emit = 1'b1;
      sc_mode = MODE_DONE;
    end else if (char_code == CH_HASH) begin
      sc_mode = MODE_COMMENT;
    end else if (char_code == CH_LBRACE) begin
      sc_emit = 1'b1;
      sc_info = mk_info(KIND_LBRACE, char_code, 1'b1, 1'b1, ERR_NONE);
    end else if (char_code == CH_RBRACE) begin
      sc_emit = 1'b1;
      sc_info = mk_info(KIND_RBRACE, char_code, 1'b1, 1'b1, ERR_NONE);
    end else if (char_code == CH_EQUAL) begin
      sc_emit = 1'b1;
      sc_info = mk_info(KIND_EQUAL, char_code, 1'b1, 1'b1, ERR_NONE);
    end else if (char_code == CH_QUOTE) begin
      sc_mode = MODE_STRING;
    end else if (is_digit(char_code)) begin
      sc_emit    = 1'b1;
      sc_set_acc = 1'b1;
      sc_mode    = MODE_NUMERAL;
      sc_info    = mk_info(KIND_NUMERAL, char_code, 1'b1, 1'b0, ERR_NONE);
    end else if (is_alpha(char_code) || char_code == CH_UNDERLINE) begin
      sc_emit = 1'b1;
      sc_mode = MODE_IDENT;
      sc_info = mk_info(KIND_IDENT, char_code, 1'b1, 1'b0, ERR_NONE);
    end else begin
      sc_emit = 1'b1;
      sc_mode = MODE_DONE;
      sc_info = mk_info(KIND_ERROR, 8'h00, 1'b0, 1'b1, ERR_SYMBOL);
    end
  end

  always_comb begin
    esc_ok = 1'b1;
    case (char_code)
      CH_LOWER_N:   esc_byte = CH_LF;
      CH_LOWER_T:   esc_byte = CH_TAB;
      CH_LOWER_R:   esc_byte = CH_CR;
      CH_BACKSLASH: esc_byte = CH_BACKSLASH;
      default: begin
        esc_byte = 8'h00;
        esc_ok   = 1'b0;
      end
    endcase
  end

  assign close_kind = (mode == MODE_NUMERAL) ? KIND_NUMERAL
                    : (mode == MODE_IDENT)   ? KIND_IDENT : KIND_STRING;
  assign close_info = mk_info(close_kind, 8'h00, 1'b0, 1'b1, ERR_NONE);

  always_comb begin
    mode_next       = mode;
    cur_row_next    = cur_row;
    cur_col_next    = cur_col;
    token_row_next  = token_row;
    token_col_next  = token_col;
    number_acc_next = number_acc;
    prev_nl_next    = prev_nl;
    res_count       = 2'd0;
    info0           = mk_info(KIND_END, 8'h00, 1'b0, 1'b1, ERR_NONE);
    info1           = mk_info(KIND_END, 8'h00, 1'b0, 1'b1, ERR_NONE);
    num0            = '0;
    num1            = '0;
    row0            = row;
    col0            = col;
    row1            = row;
    col1            = col;

    if (advance && mode != MODE_DONE) begin
      if (end_of_input) begin
        mode_next = MODE_DONE;
        res_count = 2'd1;
        case (mode)
          MODE_NUMERAL, MODE_IDENT: begin
            res_count = 2'd2;
            info0     = close_info;
            num0      = (mode == MODE_NUMERAL) ? number_acc : '0;
            row0      = token_row;
            col0      = token_col;
          end
          MODE_STRING: info0 = mk_info(KIND_ERROR, 8'h00, 1'b0, 1'b1, ERR_SYMBOL);
          MODE_ESCAPE: info0 = mk_info(KIND_ERROR, 8'h00, 1'b0, 1'b1, ERR_ESCAPE);
          default: ;
        endcase
      end else begin
        cur_row_next = row;
        cur_col_next = sat_inc(col);
        prev_nl_next = (char_code == CH_LF);
        case (mode)
          MODE_START: begin
            res_count = {1'b0, sc_emit};
            info0     = sc_info;
            num0      = sc_set_acc ? digit_val : '0;
            mode_next = sc_mode;
            if (sc_set_pos) begin
              token_row_next = row;
              token_col_next = col;
            end
            if (sc_set_acc) begin
              number_acc_next = digit_val;
            end
          end
          MODE_COMMENT: begin
            if (char_code == CH_LF) begin
              mode_next = MODE_START;
            end
          end
          MODE_NUMERAL, MODE_IDENT: begin
            if ((mode == MODE_NUMERAL && is_digit(char_code)) ||
                (mode == MODE_IDENT && is_ident_tail(char_code))) begin
              res_count = 2'd1;
              info0     = mk_info(close_kind, char_code, 1'b1, 1'b0, ERR_NONE);
              row0      = token_row;
              col0      = token_col;
              if (mode == MODE_NUMERAL) begin
                num0            = acc_grown;
                number_acc_next = acc_grown;
              end
            end else begin
              // The token closes first, then the character opens the next one.
              res_count = sc_emit ? 2'd2 : 2'd1;
              info0     = close_info;
              num0      = (mode == MODE_NUMERAL) ? number_acc : '0;
              row0      = token_row;
              col0      = token_col;
              info1     = sc_info;
              num1      = sc_set_acc ? digit_val : '0;
              mode_next = sc_mode;
              if (sc_set_pos) begin
                token_row_next = row;
                token_col_next = col;
              end
              if (sc_set_acc) begin
                number_acc_next = digit_val;
              end
            end
          end
          MODE_STRING: begin
            if (char_code == CH_QUOTE) begin
              res_count = 2'd1;
              info0     = close_info;
              row0      = token_row;
              col0      = token_col;
              mode_next = MODE_START;
            end else if (char_code == CH_BACKSLASH) begin
              mode_next = MODE_ESCAPE;
            end else if (char_code < CH_SPACE || char_code > CH_TILDE) begin
              res_count = 2'd1;
              info0     = mk_info(KIND_ERROR, 8'h00, 1'b0, 1'b1, ERR_SYMBOL);
              mode_next = MODE_DONE;
            end else begin
              res_count = 2'd1;
              info0     = mk_info(KIND_STRING, char_code, 1'b1, 1'b0, ERR_NONE);
              row0      = token_row;
              col0      = token_col;
            end
          end
          MODE_ESCAPE: begin
            res_count = 2'd1;
            if (esc_ok) begin
              info0     = mk_info(KIND_STRING, esc_byte, 1'b1, 1'b0, ERR_NONE);
              row0      = token_row;
              col0      = token_col;
              mode_next = MODE_STRING;
            end else begin
              info0     = mk_info(KIND_ERROR, 8'h00, 1'b0, 1'b1, ERR_ESCAPE);
              mode_next = MODE_DONE;
            end
          end
          default: mode_next = MODE_DONE;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_START;
      cur_row    <= POS_BITS'(1);
      cur_col    <= POS_BITS'(1);
      token_row  <= '0;
      token_col  <= '0;
      number_acc <= '0;
      prev_nl    <= 1'b0;
    end else begin
      mode       <= mode_next;
      cur_row    <= cur_row_next;
      cur_col    <= cur_col_next;
      token_row  <= token_row_next;
      token_col  <= token_col_next;
      number_acc <= number_acc_next;
      prev_nl    <= prev_nl_next;
    end
  end

  // Once finished, the lexer stays finished until reset.
  a_done_sticks: assert property (@(posedge clk) disable iff (rst)
    mode == MODE_DONE |=> mode == MODE_DONE)
    else $error("lexer left the finished mode");

  // Any error word puts the lexer in the finished mode.
  a_error_ends: assert property (@(posedge clk) disable iff (rst)
    (advance && res_count != 2'd0 && info0.kind == KIND_ERROR) |=> mode == MODE_DONE)
    else $error("error word without finishing");

  // A pair of words always starts with a bare token close.
  a_pair_close: assert property (@(posedge clk) disable iff (rst)
    (advance && res_count == 2'd2) |-> (info0.tok_end && !info0.has_byte))
    else $error("two words without a leading token close");

endmodule

### src/config_text_lexer_top.sv
// Top level of the configuration text lexer: input register, lexer step and result queue.
`timescale 1ns / 1ps

// Channel  Handshake            Word
// input    in_valid/in_ready    char_code, end_of_input
// output   out_valid/out_ready  token_kind, text_byte, has_byte, token_end,
//                               number_value, start_row, start_col, error_code
//
// A character word is taken into an input register, lexed by one pass of combinational
// logic once the queue has room for two words, and written as zero, one or two words into
// a four-word result queue; the words are registered there and leave it in order.
// One character is taken per cycle while the queue has room for two words. The output
// hands out one word per cycle, so stalls arise when the consumer holds off and when a
// run of characters that each close one token and open the next yields two words each.
// Reset is synchronous and returns the lexer to its start mode at row one, column one.
module config_text_lexer_top #(
  parameter int POS_BITS    = 16,
  parameter int NUMBER_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [7:0]             char_code,
  input  logic                   end_of_input,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [2:0]             token_kind,
  output logic [7:0]             text_byte,
  output logic                   has_byte,
  output logic                   token_end,
  output logic [NUMBER_BITS-1:0] number_value,
  output logic [POS_BITS-1:0]    start_row,
  output logic [POS_BITS-1:0]    start_col,
  output logic [1:0]             error_code
);

  import cfl_pkg::*;

  // The queue holds four words so that a character can be lexed every cycle while one
  // word is in flight to the consumer.
  localparam int QUEUE_DEPTH = 4;
  localparam int WORD_BITS   = INFO_BITS + NUMBER_BITS + 2 * POS_BITS;

  logic                   held_valid;
  logic [7:0]             held_char;
  logic                   held_eoi;
  logic                   room_for_two;
  logic                   advance;

  logic [1:0]             res_count;
  tok_info_t              info0, info1, out_info;
  logic [NUMBER_BITS-1:0] num0, num1;
  logic [POS_BITS-1:0]    row0, col0, row1, col1;
  logic [WORD_BITS-1:0]   word0, word1, out_word;

  // The held character is lexed whenever the queue can take both possible words.
  assign advance  = held_valid && room_for_two;
  assign in_ready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_char <= char_code;
      held_eoi  <= end_of_input;
    end
  end

  cfl_step #(
    .POS_BITS    (POS_BITS),
    .NUMBER_BITS (NUMBER_BITS)
  ) u_step (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .char_code    (held_char),
    .end_of_input (held_eoi),
    .res_count    (res_count),
    .info0        (info0),
    .info1        (info1),
    .num0         (num0),
    .num1         (num1),
    .row0         (row0),
    .col0         (col0),
    .row1         (row1),
    .col1         (col1)
  );

  assign word0 = {info0, num0, row0, col0};
  assign word1 = {info1, num1, row1, col1};

  cfl_queue #(
    .WIDTH (WORD_BITS),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk          (clk),
    .rst          (rst),
    .push_count   (advance ? res_count : 2'd0),
    .push_data0   (word0),
    .push_data1   (word1),
    .room_for_two (room_for_two),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_word)
  );

  // Unpack the head word onto the output fields.
  assign out_info     = tok_info_t'(out_word[WORD_BITS-1 -: INFO_BITS]);
  assign number_value = out_word[2*POS_BITS +: NUMBER_BITS];
  assign start_row    = out_word[POS_BITS +: POS_BITS];
  assign start_col    = out_word[POS_BITS-1:0];
  assign token_kind   = out_info.kind;
  assign text_byte    = out_info.text;
  assign has_byte     = out_info.has_byte;
  assign token_end    = out_info.tok_end;
  assign error_code   = out_info.err;

endmodule
